@@ rtl/core/mvrc_pkg.sv @@
// Shared types and constants of the motion vector rate cost block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mvrc_pkg;

  // Field and register widths
  localparam int MV_W     = 16;
  localparam int DIFF_W   = 21;   // wide enough for (mv << 3) - pred
  localparam int CODE_W   = 20;   // signed exp-Golomb code number
  localparam int LEN_W    = 6;    // one component length, at most 39
  localparam int BITS_W   = 7;    // sum of both lengths
  localparam int LAMBDA_W = 32;
  localparam int COST_W   = 32;
  localparam int FRAC_W   = 16;   // fractional bits of lambda
  localparam int SHIFT_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAMBDA     = 3'd0,
    REG_SCALE      = 3'd1,
    REG_PRED_HOR   = 3'd2,
    REG_PRED_VER   = 3'd3
  } cfg_reg_t;

  typedef logic signed [MV_W-1:0] mv_t;
  typedef logic [CODE_W-1:0]      code_t;
  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [BITS_W-1:0]      bits_t;

endpackage

@@ rtl/core/mvrc_code_num.sv @@
// Scaled difference and signed exp-Golomb code number of one vector component.
// Depends on mvrc_pkg.
`timescale 1ns / 1ps

module mvrc_code_num (
  input  mvrc_pkg::mv_t                     mv,
  input  mvrc_pkg::mv_t                     pred,
  input  logic [mvrc_pkg::SHIFT_W-1:0]      scale_shift,
  output mvrc_pkg::code_t                   code
);
  import mvrc_pkg::*;

  logic signed [DIFF_W-1:0] mv_ext;
  logic signed [DIFF_W-1:0] pred_ext;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] mag;
  logic                     pos;

  // d = (mv << s) - pred, exact at 21 bits
  assign mv_ext   = DIFF_W'(mv) <<< scale_shift;
  assign pred_ext = DIFF_W'(pred);
  assign diff     = mv_ext - pred_ext;

  // v = 2d for d > 0, else -2d + 1; |d| stays below 2^19
  assign pos  = !diff[DIFF_W-1] && (diff != '0);
  assign mag  = pos ? diff : -diff;
  assign code = {mag[CODE_W-2:0], ~pos};

endmodule

@@ rtl/core/mvrc_eg_len.sv @@
// Leading-one detector giving the exp-Golomb code length 1 + 2*floor(log2(v)).
// Depends on mvrc_pkg.
`timescale 1ns / 1ps

module mvrc_eg_len (
  input  mvrc_pkg::code_t code,
  output mvrc_pkg::len_t  len
);
  import mvrc_pkg::*;

  logic [LEN_W-2:0] msb_pos;

  // Highest set bit; v is never zero
  always_comb begin
    msb_pos = '0;
    for (int i = 1; i < CODE_W; i++) begin
      if (code[i]) begin
        msb_pos = (LEN_W-1)'(i);
      end
    end
  end

  assign len = {msb_pos, 1'b1};

endmodule

@@ rtl/core/motion_vector_rate_cost.sv @@
// Top level of the motion vector rate cost block: config registers and pipeline.
// Depends on mvrc_pkg, mvrc_code_num and mvrc_eg_len.
`timescale 1ns / 1ps

// Usage:
//   Input stream in_*: one candidate vector per request, tdata = {mv_ver, mv_hor}.
//   Output stream out_*: one result per candidate, tdata = {weighted_cost, bit_count}.
//   Config port cfg_*: write lambda, scale shift and predictor while idle;
//   indexes beyond the register list are ignored.
// Pipeline of three register stages:
//   stage 1 - scaled difference and code number of both components
//   stage 2 - leading-one detectors and sum of the two lengths
//   stage 3 - 7x32 lambda multiply, holds the result offered on out_*
// A new candidate can be accepted every cycle while no stall backs up to the
// input; the multiply in stage 3 and the leading-one detectors in stage 2 set
// the clock period.
// Reset clears all valid bits and the config registers; data registers are not reset.
// When the receiver stalls, each stage holds its request; empty stages ahead
// still fill, so the input keeps accepting until the pipeline is full.
module motion_vector_rate_cost (
  input  logic                                clk,
  input  logic                                rst_n,
  // config write port
  input  logic                                cfg_we,
  input  logic [mvrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mvrc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mvrc_pkg::IN_DATA_W-1:0]      in_tdata,  // mv_hor[15:0], mv_ver[31:16]
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mvrc_pkg::OUT_DATA_W-1:0]     out_tdata  // bit_count[6:0], weighted_cost[38:7]
);
  import mvrc_pkg::*;

  // Configuration registers
  logic [LAMBDA_W-1:0] lambda_r;
  logic [SHIFT_W-1:0]  scale_r;
  mv_t                 pred_hor_r;
  mv_t                 pred_ver_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lambda_r   <= '0;
      scale_r    <= '0;
      pred_hor_r <= '0;
      pred_ver_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LAMBDA:   lambda_r   <= cfg_wdata[LAMBDA_W-1:0];
        REG_SCALE:    scale_r    <= cfg_wdata[SHIFT_W-1:0];
        REG_PRED_HOR: pred_hor_r <= cfg_wdata[MV_W-1:0];
        REG_PRED_VER: pred_ver_r <= cfg_wdata[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshakes: a stage loads when empty or when the next one moves
  logic s1_vld_r, s2_vld_r, s3_vld_r;
  logic s1_rdy, s2_rdy, s3_rdy;
  logic in_fire;

  assign s3_rdy    = !s3_vld_r || out_tready;
  assign s2_rdy    = !s2_vld_r || s3_rdy;
  assign s1_rdy    = !s1_vld_r || s2_rdy;
  assign in_tready = s1_rdy;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_r <= in_tvalid;
      if (s2_rdy) s2_vld_r <= s1_vld_r;
      if (s3_rdy) s3_vld_r <= s2_vld_r;
    end
  end

  // Stage 1: code numbers
  code_t code_hor_nxt, code_ver_nxt;
  code_t code_hor_r, code_ver_r;

  mvrc_code_num u_code_hor (
    .mv          (mv_t'(in_tdata[MV_W-1:0])),
    .pred        (pred_hor_r),
    .scale_shift (scale_r),
    .code        (code_hor_nxt)
  );

  mvrc_code_num u_code_ver (
    .mv          (mv_t'(in_tdata[2*MV_W-1:MV_W])),
    .pred        (pred_ver_r),
    .scale_shift (scale_r),
    .code        (code_ver_nxt)
  );

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      code_hor_r <= code_hor_nxt;
      code_ver_r <= code_ver_nxt;
    end
  end

  // Stage 2: code lengths and their sum
  len_t  len_hor, len_ver;
  bits_t bits_nxt;
  bits_t s2_bits_r;

  mvrc_eg_len u_len_hor (.code(code_hor_r), .len(len_hor));
  mvrc_eg_len u_len_ver (.code(code_ver_r), .len(len_ver));

  assign bits_nxt = BITS_W'(len_hor) + BITS_W'(len_ver);

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_bits_r <= bits_nxt;
    end
  end

  // Stage 3: lambda weighting, product wraps at 32 bits
  logic [BITS_W+LAMBDA_W-1:0] prod_full;
  logic [COST_W-1:0]          prod_low;
  logic [COST_W-1:0]          cost_nxt;
  bits_t                      s3_bits_r;
  logic [COST_W-1:0]          s3_cost_r;

  assign prod_full = (BITS_W+LAMBDA_W)'(s2_bits_r) * (BITS_W+LAMBDA_W)'(lambda_r);
  assign prod_low  = prod_full[COST_W-1:0];
  assign cost_nxt  = prod_low >> FRAC_W;

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_bits_r <= s2_bits_r;
      s3_cost_r <= cost_nxt;
    end
  end

  assign out_tvalid = s3_vld_r;
  assign out_tdata  = {(OUT_DATA_W-BITS_W-COST_W)'(0), s3_cost_r, s3_bits_r};

  // Assertions
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_vld_r)
    else $error("accepted request did not reach stage 1");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && !s3_rdy |=> s2_vld_r && $stable(s2_bits_r))
    else $error("stage 2 lost its request during a stall");

  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (s3_bits_r >= BITS_W'(2)) && (s3_bits_r <= BITS_W'(78)))
    else $error("bit count out of range");

  a_cost_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (s3_cost_r[COST_W-1:COST_W-FRAC_W] == '0))
    else $error("weighted cost has bits above the shifted product");

endmodule

@@ tb/sv/tb_motion_vector_rate_cost.sv @@
// Self-checking testbench for motion_vector_rate_cost: a directed table, then random
// candidate vectors under several register settings, with random stalls on both streams.
// Depends on mvrc_pkg and the motion_vector_rate_cost RTL.
`timescale 1ns / 1ps

module tb_motion_vector_rate_cost;
  import mvrc_pkg::*;

  localparam int NUM_REGS   = 4;
  localparam int IDLE_LIMIT = 1000;   // cycles without any handshake
  localparam int HOLD_LEN   = 80;     // long receiver hold-off
  localparam int PHASES     = 6;
  localparam int PHASE_VECS = 80;

  typedef struct packed {
    bits_t       bits;
    logic [31:0] cost;
  } cost_res_t;

  // Directed row: optional register load, candidate, optional typed-in result
  typedef struct packed {
    logic        wr;
    logic [31:0] lam;
    logic [31:0] sh;
    logic [31:0] ph;
    logic [31:0] pv;
    mv_t         mh;
    mv_t         mv;
    logic        known;
    bits_t       bits;
    logic [31:0] cost;
  } dir_row_t;

  dir_row_t dir_tab [0:12] = '{
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'sh0000, 16'sh0000, 1'b1, 7'd2, 32'd0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'sh8000, 16'sh7FFF, 1'b1, 7'd64, 32'd0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'sh0001, 16'shFFFF, 1'b1, 7'd6, 32'd0},
    '{1'b1, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 16'sh0000, 16'sh0000, 1'b1, 7'd2, 32'd2},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'sh7FFF, 16'sh8000, 1'b1, 7'd64, 32'd64},
    // widest differences, lambda all ones: product wraps
    '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_7FFF,
      16'sh7FFF, 16'sh8000, 1'b1, 7'd78, 32'h0000_FFFF},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'shF000, 16'sh1000, 1'b0, 7'd0, 32'd0},
    // upper register bits set, must be masked
    '{1'b1, 32'h0001_2345, 32'hFFFF_FFFD, 32'd100, 32'hFFFF_FF9C,
      16'sd50, -16'sd50, 1'b0, 7'd0, 32'd0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'sh7FFF, 16'sh8000, 1'b0, 7'd0, 32'd0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'shFFFF, 16'sh0000, 1'b0, 7'd0, 32'd0},
    '{1'b1, 32'h8000_0000, 32'd2, 32'h0000_7FFF, 32'hABCD_8000,
      16'shFFFF, 16'sh0001, 1'b0, 7'd0, 32'd0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'sh0000, 16'sh0000, 1'b0, 7'd0, 32'd0},
    '{1'b1, 32'h0, 32'd3, 32'h0, 32'h0, 16'sh7FFF, 16'sh8000, 1'b0, 7'd0, 32'd0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // mv_hor[15:0], mv_ver[31:16]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // bit_count[6:0], weighted_cost[38:7]

  // Register copy used for prediction
  logic [31:0]      lam_q;
  logic [1:0]       shift_q;
  mv_t              pred_h_q;
  mv_t              pred_v_q;

  cost_res_t        expected_costs [$];
  int               vec_sent;
  int               cost_checked;
  int               mismatch_cnt;
  int               cfg_sets;
  int               idle_cycles;
  int               gap_pct;
  int               stall_left;
  bit               hold_ask;

  motion_vector_rate_cost dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Signed exp-Golomb length of one scaled difference
  function automatic int unsigned code_length(mv_t comp, mv_t pred);
    longint            d;
    longint unsigned   v;
    int unsigned       len;
    d = (longint'(comp) <<< shift_q) - longint'(pred);
    v = (d > 0) ? 2 * d : -2 * d + 1;
    len = 1;
    while (v > 1) begin
      v >>= 1;
      len += 2;
    end
    return len;
  endfunction

  function automatic cost_res_t predict_rate_cost(mv_t mh, mv_t mv);
    cost_res_t   r;
    logic [31:0] prod;
    int unsigned total;
    total = code_length(mh, pred_h_q) + code_length(mv, pred_v_q);
    prod = lam_q * total;  // wraps at 32 bits
    r.bits = total[BITS_W-1:0];
    r.cost = prod >> FRAC_W;
    return r;
  endfunction

  // One register write; caller lowers cfg_we after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_LAMBDA:   lam_q = data;
      REG_SCALE:    shift_q = data[SHIFT_W-1:0];
      REG_PRED_HOR: pred_h_q = data[MV_W-1:0];
      REG_PRED_VER: pred_v_q = data[MV_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Full register load plus a write to an unmapped index
  task automatic load_cfg(input logic [31:0] lam, input logic [31:0] sh,
                          input logic [31:0] ph, input logic [31:0] pv);
    write_reg(REG_LAMBDA, lam);
    write_reg(REG_SCALE, sh);
    write_reg(REG_PRED_HOR, ph);
    write_reg(REG_PRED_VER, pv);
    write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 7)), $urandom);
    cfg_we <= 1'b0;
    cfg_sets++;
  endtask

  // Offer one candidate, record its expectation on acceptance
  task automatic send_vec(input mv_t mh, input mv_t mv, input cost_res_t exp_res);
    in_tvalid <= 1'b1;
    in_tdata  <= {mv, mh};
    do @(posedge clk); while (!in_tready);
    expected_costs.push_back(exp_res);
    vec_sent++;
    @(negedge clk);
  endtask

  task automatic idle_in(input int n);
    in_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Pause until every expected result has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_costs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Pick a register value: an extreme, zero or a random word
  function automatic logic [31:0] pick_word(input logic [31:0] lo, input logic [31:0] hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stall bursts, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_ask) begin
      hold_ask = 1'b0;
      stall_left = HOLD_LEN;
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < gap_pct) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(1, 9) - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    cost_res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_costs.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("ERROR: result with nothing pending, tdata=%h", out_tdata);
      end else begin
        exp_res = expected_costs.pop_front();
        cost_checked++;
        if (out_tdata[BITS_W-1:0] !== exp_res.bits ||
            out_tdata[BITS_W +: COST_W] !== exp_res.cost) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: result %0d: bits exp %0d got %0d, cost exp %h got %h",
                     cost_checked, exp_res.bits, out_tdata[BITS_W-1:0],
                     exp_res.cost, out_tdata[BITS_W +: COST_W]);
        end
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    cost_res_t exp_res;
    mv_t       mh;
    mv_t       mv;
    mv_t       near_h;
    mv_t       near_v;
    int        ofs;

    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    lam_q = '0;
    shift_q = '0;
    pred_h_q = '0;
    pred_v_q = '0;
    vec_sent = 0;
    cost_checked = 0;
    mismatch_cnt = 0;
    cfg_sets = 0;
    idle_cycles = 0;
    gap_pct = 20;
    stall_left = 0;
    hold_ask = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table; first rows run on the reset values
    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr) begin
        drain_results();
        load_cfg(dir_tab[i].lam, dir_tab[i].sh, dir_tab[i].ph, dir_tab[i].pv);
      end
      if (dir_tab[i].known) begin
        exp_res.bits = dir_tab[i].bits;
        exp_res.cost = dir_tab[i].cost;
      end else begin
        exp_res = predict_rate_cost(dir_tab[i].mh, dir_tab[i].mv);
      end
      if ($urandom_range(0, 99) < gap_pct) idle_in($urandom_range(1, 9));
      send_vec(dir_tab[i].mh, dir_tab[i].mv, exp_res);
    end

    // Random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      load_cfg(pick_word(32'h0, 32'hFFFF_FFFF), $urandom,
               pick_word(32'h0000_8000, 32'h0000_7FFF),
               pick_word(32'h0000_8000, 32'h0000_7FFF));
      case (p % 3)
        0: gap_pct = 40;
        1: gap_pct = 15;
        default: gap_pct = 0;
      endcase
      if (p == PHASES - 1) gap_pct = 0;
      near_h = pred_h_q >>> shift_q;
      near_v = pred_v_q >>> shift_q;
      for (int k = 0; k < PHASE_VECS; k++) begin
        if (p == 1 && k == 20) hold_ask = 1'b1;
        if (p == 3 && k == 40) drain_results();
        if ($urandom_range(0, 99) < gap_pct) idle_in($urandom_range(1, 9));
        // about a quarter land near the predictor: zero and tiny differences
        if ($urandom_range(0, 3) == 0) begin
          ofs = $urandom_range(0, 6);
          mh = mv_t'(near_h + ofs - 3);
          ofs = $urandom_range(0, 6);
          mv = mv_t'(near_v + ofs - 3);
        end else begin
          mh = mv_t'($urandom);
          mv = mv_t'($urandom);
        end
        send_vec(mh, mv, predict_rate_cost(mh, mv));
      end
    end

    drain_results();
    repeat (10) @(negedge clk);

    $display("Summary: %0d candidate vectors over %0d register settings, %0d results checked",
             vec_sent, cfg_sets + 1, cost_checked);
    $display("Summary: %0d mismatches, %0d results still pending",
             mismatch_cnt, expected_costs.size());
    if (mismatch_cnt == 0 && expected_costs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
